### design/pse_pkg.sv
// Package for the postfix stack evaluator: sizes, instruction and status
// codes, queue entry and divider handshake types. No dependencies.
`default_nettype none
package pse_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int DW = $clog2(STACK_DEPTH + 1);  // depth counter width
  localparam int AW = $clog2(STACK_DEPTH);      // stack address width
  localparam int XW = 32;                       // value width

  typedef enum logic [3:0] {
    OP_PUSH   = 4'd0,
    OP_ADD    = 4'd1,
    OP_SUB    = 4'd2,
    OP_MUL    = 4'd3,
    OP_DIV    = 4'd4,
    OP_REM    = 4'd5,
    OP_LT     = 4'd6,
    OP_GT     = 4'd7,
    OP_EQ     = 4'd8,
    OP_POP    = 4'd9,
    OP_SWAP   = 4'd10,
    OP_SEL    = 4'd11,
    OP_NGET   = 4'd12,
    OP_FINISH = 4'd13,
    OP_CLEAR  = 4'd14
  } op_t;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK   = 3'd0;
  localparam status_t ST_FEW  = 3'd1;
  localparam status_t ST_DIVZ = 3'd2;
  localparam status_t ST_IDX  = 3'd3;
  localparam status_t ST_OVF  = 3'd4;
  localparam status_t ST_FIN  = 3'd5;
  localparam status_t ST_HALT = 3'd6;

  // queue entry: opcode plus front-end classification
  typedef struct packed {
    op_t           op;
    logic          arith;    // two-operand arithmetic or compare
    logic          divide;   // div or rem, goes through the divider
    logic [XW-1:0] literal;
  } entry_t;

  typedef struct packed {
    logic          start;
    logic [XW-1:0] num;
    logic [XW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [XW-1:0] quo;
    logic [XW-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

### design/postfix_stack_evaluator.sv
// Postfix stack evaluator top level. Push, clear, finish, errors and a pop
// that empties the stack complete in the decode state; other pops and nget
// go through the read state S_RDA; binary ops and swap then go through S_WR2,
// sel through S_RDC; div and rem wait in S_DIV on the divider (one quotient
// bit per cycle). The sequencer takes the next instruction only when idle.
// Synchronous active-low reset empties the stack and the 2-entry queue and
// clears halt; no clearing pass.
`default_nettype none
module postfix_stack_evaluator import pse_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_op,
  input  wire logic [31:0] in_literal,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [31:0]      out_top_value,
  output logic [8:0]       out_depth,
  output logic             out_done_res
);

  logic   q_valid;
  entry_t q_entry;
  logic   q_pop;

  pse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_literal (in_literal),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop)
  );

  pse_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_top_value (out_top_value),
    .out_depth     (out_depth),
    .out_done_res  (out_done_res)
  );

endmodule
`default_nettype wire

### design/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/pse_front.sv
// Front end: accepts instructions, classifies them and queues them (2 deep).
// Depends on pse_pkg.
`default_nettype none
module pse_front import pse_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [3:0] in_op,
  input  wire logic [31:0] in_literal,
  output logic            q_valid,
  output entry_t          q_entry,
  input  wire logic       q_pop
);

  entry_t     ent_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  entry_t     new_ent;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_entry  = ent_r[rptr_r];
  assign push     = in_valid && in_ready;

  always_comb begin
    new_ent.op      = op_t'(in_op);
    new_ent.arith   = (in_op >= 4'(OP_ADD)) && (in_op <= 4'(OP_EQ));
    new_ent.divide  = (in_op == 4'(OP_DIV)) || (in_op == 4'(OP_REM));
    new_ent.literal = in_literal;
  end

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = q_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= new_ent;
    end
  end

endmodule
`default_nettype wire

### design/pse_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating.
// Depends on pse_pkg.
`default_nettype none
module pse_div import pse_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  div_req_t  req,
  output div_rsp_t  rsp
);

  localparam int CW = $clog2(XW + 1);

  logic [XW-1:0] rem_r, rem_nxt;
  logic [XW-1:0] quo_r, quo_nxt;
  logic [XW-1:0] den_r, den_nxt;
  logic          negq_r, negq_nxt;
  logic          negr_r, negr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [XW:0]   shifted;
  logic [XW:0]   diff;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    negq_nxt = negq_r;
    negr_nxt = negr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[XW-1]};
    diff     = shifted - {1'b0, den_r};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.num[XW-1] ? (~req.num + 1'b1) : req.num;
      den_nxt  = req.den[XW-1] ? (~req.den + 1'b1) : req.den;
      negq_nxt = req.num[XW-1] ^ req.den[XW-1];
      negr_nxt = req.num[XW-1];
      cnt_nxt  = CW'(XW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[XW]) begin
        rem_nxt = diff[XW-1:0];
        quo_nxt = {quo_r[XW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[XW-1:0];
        quo_nxt = {quo_r[XW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    negq_r <= negq_nxt;
    negr_r <= negr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = negq_r ? (~quo_r + 1'b1) : quo_r;
  assign rsp.rem  = negr_r ? (~rem_r + 1'b1) : rem_r;

endmodule
`default_nettype wire

### design/pse_back.sv
// Back end: executes queued instructions against the stack RAM, keeps the
// top value and depth in registers, and holds the result register.
// Depends on pse_pkg, pse_ram and pse_div.
`default_nettype none
module pse_back import pse_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  entry_t     q_entry,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_top_value,
  output logic [8:0]  out_depth,
  output logic        out_done_res
);

  typedef enum logic [4:0] {
    S_DEC = 5'b00001,
    S_RDA = 5'b00010,
    S_RDC = 5'b00100,
    S_WR2 = 5'b01000,
    S_DIV = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [XW-1:0] top_r, top_nxt;
  logic          halted_r, halted_nxt;
  op_t           op_r, op_nxt;
  logic [XW-1:0] a_r, a_nxt;
  logic [XW-1:0] b_r, b_nxt;

  logic          ovalid_r, ovalid_nxt;
  status_t       ostat_r, ostat_nxt;
  logic [XW-1:0] otop_r, otop_nxt;
  logic [8:0]    odep_r, odep_nxt;
  logic          odone_r, odone_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [XW-1:0] wdata, rdata;
  div_req_t      dreq;
  div_rsp_t      drsp;

  logic          slot_free;
  logic          fin;
  status_t       fstat;
  logic [XW-1:0] ftop;
  logic          fdone;
  logic [DW-1:0] dm1, dm2, dm3;
  logic          nget_bad;
  logic [XW-1:0] alu;

  pse_ram #(.WIDTH(XW), .DEPTH(STACK_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  pse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign slot_free = !ovalid_r || out_ready;
  assign dm1 = d_r - DW'(1);
  assign dm2 = d_r - DW'(2);
  assign dm3 = d_r - DW'(3);
  assign nget_bad = top_r[XW-1] || (top_r == '0) || (top_r > XW'(dm1));

  always_comb begin
    case (op_r)
      OP_ADD:  alu = a_r + b_r;
      OP_SUB:  alu = a_r - b_r;
      OP_MUL:  alu = a_r * b_r;
      OP_LT:   alu = XW'($signed(a_r) < $signed(b_r));
      OP_GT:   alu = XW'($signed(a_r) > $signed(b_r));
      OP_EQ:   alu = XW'(a_r == b_r);
      default: alu = '0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    d_nxt      = d_r;
    top_nxt    = top_r;
    halted_nxt = halted_r;
    op_nxt     = op_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    q_pop      = 1'b0;
    we         = 1'b0;
    waddr      = dm2[AW-1:0];
    wdata      = '0;
    raddr      = dm2[AW-1:0];
    dreq.start = 1'b0;
    dreq.num   = a_r;
    dreq.den   = b_r;
    fin        = 1'b0;
    fstat      = ST_OK;
    ftop       = top_r;
    fdone      = 1'b0;

    case (state_r)
      S_DEC: begin
        if (q_valid && slot_free) begin
          q_pop  = 1'b1;
          op_nxt = q_entry.op;
          b_nxt  = top_r;
          if (q_entry.op == OP_CLEAR) begin
            d_nxt      = '0;
            top_nxt    = '0;
            halted_nxt = 1'b0;
            fin        = 1'b1;
            ftop       = '0;
          end else if (halted_r) begin
            fin   = 1'b1;
            fstat = ST_HALT;
          end else if (q_entry.arith) begin
            if (d_r < DW'(2)) begin
              fin = 1'b1; fstat = ST_FEW;
            end else if (q_entry.divide && (top_r == '0)) begin
              fin = 1'b1; fstat = ST_DIVZ;
            end else begin
              state_nxt = S_RDA;
            end
          end else begin
            case (q_entry.op)
              OP_PUSH: begin
                if (d_r >= DW'(STACK_DEPTH)) begin
                  fin = 1'b1; fstat = ST_OVF;
                end else begin
                  we      = 1'b1;
                  waddr   = d_r[AW-1:0];
                  wdata   = q_entry.literal;
                  d_nxt   = d_r + DW'(1);
                  top_nxt = q_entry.literal;
                  fin     = 1'b1;
                  ftop    = q_entry.literal;
                end
              end
              OP_POP: begin
                if (d_r < DW'(1)) begin
                  fin = 1'b1; fstat = ST_FEW;
                end else if (d_r == DW'(1)) begin
                  d_nxt   = '0;
                  top_nxt = '0;
                  fin     = 1'b1;
                  ftop    = '0;
                end else begin
                  state_nxt = S_RDA;
                end
              end
              OP_SWAP: begin
                if (d_r < DW'(2)) begin
                  fin = 1'b1; fstat = ST_FEW;
                end else begin
                  state_nxt = S_RDA;
                end
              end
              OP_SEL: begin
                if (d_r < DW'(3)) begin
                  fin = 1'b1; fstat = ST_FEW;
                end else begin
                  state_nxt = S_RDA;
                end
              end
              OP_NGET: begin
                if (d_r < DW'(1)) begin
                  fin = 1'b1; fstat = ST_FEW;
                end else if (nget_bad) begin
                  fin = 1'b1; fstat = ST_IDX;
                end else begin
                  raddr     = AW'(dm1 - top_r[DW-1:0]);
                  state_nxt = S_RDA;
                end
              end
              OP_FINISH: begin
                if (d_r != DW'(1)) begin
                  fin = 1'b1; fstat = ST_FIN;
                end else begin
                  d_nxt   = '0;
                  top_nxt = '0;
                  fin     = 1'b1;
                  fdone   = 1'b1;
                end
              end
              default: begin
                fin = 1'b1;
              end
            endcase
          end
          // an error leaves the stack alone and halts
          if (fin && (fstat != ST_OK) && (fstat != ST_HALT)) begin
            halted_nxt = 1'b1;
          end
        end
      end

      S_RDA: begin
        a_nxt = rdata;
        case (op_r)
          OP_DIV, OP_REM: begin
            dreq.start = 1'b1;
            dreq.num   = rdata;
            state_nxt  = S_DIV;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_LT, OP_GT, OP_EQ: begin
            // operand lands in a_r first; compute next cycle
            state_nxt = S_WR2;
          end
          OP_POP: begin
            d_nxt     = dm1;
            top_nxt   = rdata;
            fin       = 1'b1;
            ftop      = rdata;
            state_nxt = S_DEC;
          end
          OP_SWAP: begin
            we        = 1'b1;
            waddr     = dm1[AW-1:0];
            wdata     = rdata;
            top_nxt   = rdata;
            state_nxt = S_WR2;
          end
          OP_SEL: begin
            raddr     = dm3[AW-1:0];
            state_nxt = S_RDC;
          end
          OP_NGET: begin
            we        = 1'b1;
            waddr     = dm1[AW-1:0];
            wdata     = rdata;
            top_nxt   = rdata;
            fin       = 1'b1;
            ftop      = rdata;
            state_nxt = S_DEC;
          end
          default: begin
            state_nxt = S_DEC;
          end
        endcase
      end

      S_WR2: begin
        we = 1'b1;
        if (op_r == OP_SWAP) begin
          waddr = dm2[AW-1:0];
          wdata = b_r;
          fin   = 1'b1;
        end else begin
          waddr   = dm2[AW-1:0];
          wdata   = alu;
          d_nxt   = dm1;
          top_nxt = alu;
          fin     = 1'b1;
          ftop    = alu;
        end
        state_nxt = S_DEC;
      end

      S_RDC: begin
        we        = 1'b1;
        waddr     = dm3[AW-1:0];
        wdata     = (rdata != '0) ? a_r : b_r;
        d_nxt     = dm2;
        top_nxt   = wdata;
        fin       = 1'b1;
        ftop      = wdata;
        state_nxt = S_DEC;
      end

      S_DIV: begin
        if (drsp.done) begin
          we        = 1'b1;
          waddr     = dm2[AW-1:0];
          wdata     = (op_r == OP_DIV) ? drsp.quo : drsp.rem;
          d_nxt     = dm1;
          top_nxt   = wdata;
          fin       = 1'b1;
          ftop      = wdata;
          state_nxt = S_DEC;
        end
      end

      default: begin
        state_nxt = S_DEC;
      end
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r && !out_ready;
    ostat_nxt  = ostat_r;
    otop_nxt   = otop_r;
    odep_nxt   = odep_r;
    odone_nxt  = odone_r;
    if (fin) begin
      ovalid_nxt = 1'b1;
      ostat_nxt  = fstat;
      otop_nxt   = ftop;
      odep_nxt   = 9'(d_nxt);
      odone_nxt  = fdone;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_DEC;
      d_r      <= '0;
      top_r    <= '0;
      halted_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      d_r      <= d_nxt;
      top_r    <= top_nxt;
      halted_r <= halted_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    ostat_r <= ostat_nxt;
    otop_r  <= otop_nxt;
    odep_r  <= odep_nxt;
    odone_r <= odone_nxt;
  end

  assign out_valid     = ovalid_r;
  assign out_status    = ostat_r;
  assign out_top_value = otop_r;
  assign out_depth     = odep_r;
  assign out_done_res  = odone_r;

endmodule
`default_nettype wire

### design/pse_checker.sv
// Port-level checker for the postfix stack evaluator, bound to the top.
// Depends on pse_pkg.
`default_nettype none
module pse_checker import pse_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [31:0] out_top_value,
  input wire logic [8:0]  out_depth,
  input wire logic        out_done_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_top_value))
    else $error("result changed while stalled");

  a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_status == ST_OK && out_depth == 9'd0)
    else $error("finish result with bad status or depth");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res && out_depth == 9'd0 |-> out_top_value == 32'd0)
    else $error("empty stack reports nonzero top");

  a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_depth <= 9'(STACK_DEPTH))
    else $error("depth beyond stack size");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_top_value (out_top_value),
  .out_depth     (out_depth),
  .out_done_res  (out_done_res)
);
`default_nettype wire
